### rtl/core/frd_pkg.sv
// ----------------------------------------------------------------------------
// frd_pkg
// Shared types for the fraction reducer: controller states and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package frd_pkg;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;        // capture a new fraction
    logic gcd_step;    // one binary GCD iteration
    logic gcd_finish;  // form the divisor, arm the dividers
    logic div_step;    // one quotient bit for both parts
    logic publish;     // move the result into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_zero;     // incoming fraction has a zero part
    logic gcd_equal;   // GCD operands have met
    logic div_last;    // final quotient bit in this cycle
    logic out_full;    // output register holds an untaken result
  } status_t;

endpackage

### rtl/core/frd_if.sv
// ----------------------------------------------------------------------------
// frd_in_if / frd_out_if
// Valid/ready channels for fractions in and reduced fractions out.
// ----------------------------------------------------------------------------
interface frd_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] numerator;
  logic [VALUE_BITS-1:0] denominator;

  modport source (output valid, numerator, denominator, input ready);
  modport sink   (input valid, numerator, denominator, output ready);
endinterface

interface frd_out_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] reduced_numerator;
  logic [VALUE_BITS-1:0] reduced_denominator;
  logic [VALUE_BITS-1:0] common_divisor;
  logic                  zero_error;

  modport source (output valid, reduced_numerator, reduced_denominator,
                  common_divisor, zero_error, input ready);
  modport sink   (input valid, reduced_numerator, reduced_denominator,
                  common_divisor, zero_error, output ready);
endinterface

### rtl/core/frd_ctrl.sv
// ----------------------------------------------------------------------------
// frd_ctrl
// Sequencer: load, binary GCD iterations, bit-serial division, publish.
// ----------------------------------------------------------------------------
module frd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             out_ready,
  input  frd_pkg::status_t status,
  output frd_pkg::cmd_t    cmd
);

  frd_pkg::state_t state;
  frd_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      frd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = status.in_zero ? frd_pkg::ST_DONE : frd_pkg::ST_GCD;
        end
      end
      frd_pkg::ST_GCD: begin
        if (status.gcd_equal) begin
          state_next = frd_pkg::ST_DIV;
        end
      end
      frd_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_next = frd_pkg::ST_DONE;
        end
      end
      frd_pkg::ST_DONE: begin
        if (!status.out_full || out_ready) begin
          state_next = frd_pkg::ST_IDLE;
        end
      end
      default: state_next = frd_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      frd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      frd_pkg::ST_GCD: begin
        cmd.gcd_step   = !status.gcd_equal;
        cmd.gcd_finish = status.gcd_equal;
      end
      frd_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      frd_pkg::ST_DONE: begin
        cmd.publish = !status.out_full || out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/core/frd_datapath.sv
// ----------------------------------------------------------------------------
// frd_datapath
// Binary GCD unit, two restoring dividers sharing one divisor, and the
// output register.
// ----------------------------------------------------------------------------
module frd_datapath #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst,
  input  frd_pkg::cmd_t         cmd,
  output frd_pkg::status_t      status,
  input  logic [VALUE_BITS-1:0] numerator,
  input  logic [VALUE_BITS-1:0] denominator,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [VALUE_BITS-1:0] reduced_numerator,
  output logic [VALUE_BITS-1:0] reduced_denominator,
  output logic [VALUE_BITS-1:0] common_divisor,
  output logic                  zero_error
);

  localparam int KW = $clog2(VALUE_BITS + 1);
  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_BITS - 1);

  // Working registers
  logic [VALUE_BITS-1:0] num_q;   // numerator, then its quotient
  logic [VALUE_BITS-1:0] den_q;   // denominator, then its quotient
  logic [VALUE_BITS-1:0] op_a;
  logic [VALUE_BITS-1:0] op_b;
  logic [KW-1:0]         twos;    // common factors of two
  logic [VALUE_BITS-1:0] divisor;
  logic [VALUE_BITS-1:0] rem_n;
  logic [VALUE_BITS-1:0] rem_d;
  logic [CW-1:0]         bit_cnt;
  logic                  zero_part;

  logic [VALUE_BITS:0]   shift_n;
  logic [VALUE_BITS:0]   shift_d;
  logic [VALUE_BITS:0]   diff_n;
  logic [VALUE_BITS:0]   diff_d;

  // Divider trial subtraction
  always_comb begin
    shift_n = {rem_n, num_q[VALUE_BITS-1]};
    shift_d = {rem_d, den_q[VALUE_BITS-1]};
    diff_n  = shift_n - {1'b0, divisor};
    diff_d  = shift_d - {1'b0, divisor};
  end

  // Status to the controller
  always_comb begin
    status.in_zero   = (numerator == '0) || (denominator == '0);
    status.gcd_equal = (op_a == op_b);
    status.div_last  = (bit_cnt == LAST_BIT);
    status.out_full  = out_valid;
  end

  // GCD and division datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_q     <= numerator;
      den_q     <= denominator;
      op_a      <= numerator;
      op_b      <= denominator;
      twos      <= '0;
      zero_part <= (numerator == '0) || (denominator == '0);
    end else if (cmd.gcd_step) begin
      priority if (!op_a[0] && !op_b[0]) begin
        op_a <= op_a >> 1;
        op_b <= op_b >> 1;
        twos <= twos + KW'(1);
      end else if (!op_a[0]) begin
        op_a <= op_a >> 1;
      end else if (!op_b[0]) begin
        op_b <= op_b >> 1;
      end else if (op_a > op_b) begin
        op_a <= op_a - op_b;
      end else begin
        op_b <= op_b - op_a;
      end
    end else if (cmd.gcd_finish) begin
      divisor <= op_a << twos;
      rem_n   <= '0;
      rem_d   <= '0;
      bit_cnt <= '0;
    end else if (cmd.div_step) begin
      // shift in one dividend bit per part, keep remainder if it fits
      if (!diff_n[VALUE_BITS]) begin
        rem_n <= diff_n[VALUE_BITS-1:0];
      end else begin
        rem_n <= shift_n[VALUE_BITS-1:0];
      end
      if (!diff_d[VALUE_BITS]) begin
        rem_d <= diff_d[VALUE_BITS-1:0];
      end else begin
        rem_d <= shift_d[VALUE_BITS-1:0];
      end
      num_q   <= {num_q[VALUE_BITS-2:0], !diff_n[VALUE_BITS]};
      den_q   <= {den_q[VALUE_BITS-2:0], !diff_d[VALUE_BITS]};
      bit_cnt <= bit_cnt + CW'(1);
    end
  end

  // Output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      reduced_numerator   <= num_q;
      reduced_denominator <= den_q;
      common_divisor      <= zero_part ? '0 : divisor;
      zero_error          <= zero_part;
    end
  end

endmodule

### rtl/core/fraction_reducer.sv
// Operation: after accept, binary GCD iterations, then a bit-serial division
//   of both parts, then the result moves into the output register; a zero
//   part goes straight to the output register.
// Throughput: one fraction at a time; the next can be taken the cycle after the
//   result enters the output register, which may still wait for the sink.
// Reset: rst clears the controller and the output valid flag, nothing else.
// ----------------------------------------------------------------------------
// fraction_reducer
// Reduces a fraction to lowest terms: binary GCD, then both parts divided
// by the divisor bit by bit. A zero part flags an error and passes through.
// ----------------------------------------------------------------------------
module fraction_reducer #(
  parameter int VALUE_BITS = 31
) (
  input  logic      clk,
  input  logic      rst,
  frd_in_if.sink    fraction,
  frd_out_if.source result
);

  frd_pkg::cmd_t    cmd;
  frd_pkg::status_t status;

  frd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fraction.valid),
    .in_ready  (fraction.ready),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  frd_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .numerator           (fraction.numerator),
    .denominator         (fraction.denominator),
    .out_ready           (result.ready),
    .out_valid           (result.valid),
    .reduced_numerator   (result.reduced_numerator),
    .reduced_denominator (result.reduced_denominator),
    .common_divisor      (result.common_divisor),
    .zero_error          (result.zero_error)
  );

  // Checks
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    fraction.valid && fraction.ready |=> !fraction.ready)
    else $error("second transaction taken while busy");

  a_error_no_divisor: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.zero_error |-> result.common_divisor == '0)
    else $error("error result carries a divisor");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.zero_error |-> result.common_divisor != '0)
    else $error("zero divisor without error");

  a_parts_nonzero: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.zero_error |->
      result.reduced_numerator != '0 && result.reduced_denominator != '0)
    else $error("reduced part is zero");

endmodule

### tb/fraction_reducer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fraction_reducer_tb
// Self-checking bench for the fraction reducer. A queue of fractions feeds a
// bursty driver. A monitor with its own stall pattern checks every reduced
// fraction against a Euclid-based model. Directed corner cases come first:
// zero parts, equal parts, extremes and worst-case operands. Random fractions
// of mixed shapes, some built with known common factors, follow.
// ----------------------------------------------------------------------------
module fraction_reducer_tb;

  localparam int VALUE_BITS     = 31;
  localparam int RANDOM_ITEMS   = 1230;
  localparam int DRAIN_CYCLES   = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 600;

  typedef logic [VALUE_BITS-1:0] value_t;

  localparam value_t VALUE_MAX = '1;

  typedef struct packed {
    value_t numerator;
    value_t denominator;
  } fraction_t;

  typedef struct packed {
    value_t numerator;
    value_t denominator;
    value_t divisor;
    logic   zero_error;
  } reduced_t;

  logic clk;
  logic rst;

  frd_in_if  #(.VALUE_BITS(VALUE_BITS)) fraction_ch ();
  frd_out_if #(.VALUE_BITS(VALUE_BITS)) result_ch ();

  fraction_reducer #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .fraction(fraction_ch),
    .result  (result_ch)
  );

  fraction_t queued_fractions[$];
  reduced_t  pending_reductions[$];

  int error_count     = 0;
  int fractions_sent  = 0;
  int results_checked = 0;
  int zero_results    = 0;
  int directed_count  = 0;
  int holds_done      = 0;

  // Clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Reduce a fraction to lowest terms by Euclid's method
  function automatic reduced_t reduce_fraction(fraction_t f);
    value_t   a;
    value_t   b;
    value_t   r;
    reduced_t res;
    if (f.numerator == '0 || f.denominator == '0) begin
      res.numerator   = f.numerator;
      res.denominator = f.denominator;
      res.divisor     = '0;
      res.zero_error  = 1'b1;
    end else begin
      a = f.numerator;
      b = f.denominator;
      while (b != '0) begin
        r = a % b;
        a = b;
        b = r;
      end
      res.numerator   = f.numerator / a;
      res.denominator = f.denominator / a;
      res.divisor     = a;
      res.zero_error  = 1'b0;
    end
    return res;
  endfunction

  // Random value of at most the given number of bits
  function automatic value_t rand_value(int bits);
    value_t v;
    v = value_t'($urandom);
    if (bits < VALUE_BITS) begin
      v = v & ((value_t'(1) << bits) - value_t'(1));
    end
    return v;
  endfunction

  function automatic fraction_t make_fraction(value_t n, value_t d);
    fraction_t f;
    f.numerator   = n;
    f.denominator = d;
    return f;
  endfunction

  // Random fraction drawn from a mix of shapes that exercise the GCD
  function automatic fraction_t random_fraction();
    int     shape;
    int     gbits;
    value_t g;
    value_t a;
    value_t b;
    shape = $urandom_range(0, 9);
    case (shape)
      0: begin
        // zero part, sometimes both
        a = rand_value($urandom_range(1, VALUE_BITS));
        case ($urandom_range(0, 2))
          0:       return make_fraction('0, a);
          1:       return make_fraction(a, '0);
          default: return make_fraction('0, '0);
        endcase
      end
      1, 2: begin
        // known common factor times two cofactors
        gbits = $urandom_range(1, VALUE_BITS - 1);
        g = rand_value(gbits) | value_t'(1);
        a = rand_value(VALUE_BITS - gbits);
        b = rand_value(VALUE_BITS - gbits);
        if (a == '0) a = value_t'(1);
        if (b == '0) b = value_t'(1);
        return make_fraction(g * a, g * b);
      end
      3: begin
        // shared powers of two
        a = rand_value($urandom_range(1, 20)) | value_t'(1);
        b = rand_value($urandom_range(1, 20)) | value_t'(1);
        gbits = $urandom_range(0, 10);
        return make_fraction(a << gbits, b << $urandom_range(0, 10));
      end
      4: begin
        // small values
        return make_fraction(value_t'($urandom_range(1, 1000)),
                             value_t'($urandom_range(1, 1000)));
      end
      5: begin
        // equal parts
        a = rand_value($urandom_range(1, VALUE_BITS));
        if (a == '0) a = VALUE_MAX;
        return make_fraction(a, a);
      end
      6: begin
        // one part divides the other
        a = rand_value($urandom_range(1, 24)) | value_t'(1);
        b = a * value_t'($urandom_range(1, 100));
        if ($urandom_range(0, 1) == 0) return make_fraction(a, b);
        return make_fraction(b, a);
      end
      default: begin
        // full-width random values of random size
        a = rand_value($urandom_range(1, VALUE_BITS));
        b = rand_value($urandom_range(1, VALUE_BITS));
        if (a == '0) a = value_t'($urandom_range(1, 255));
        if (b == '0) b = value_t'($urandom_range(1, 255));
        return make_fraction(a, b);
      end
    endcase
  endfunction

  // Driver: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    fraction_t next_item;
    logic      next_valid;
    next_item  = '0;
    next_valid = 1'b0;
    if (rst) begin
      fraction_ch.valid <= 1'b0;
    end else begin
      if (fraction_ch.valid && fraction_ch.ready) begin
        pending_reductions.push_back(reduce_fraction(
          make_fraction(fraction_ch.numerator, fraction_ch.denominator)));
        fractions_sent++;
      end
      if (!fraction_ch.valid || fraction_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (queued_fractions.size() != 0) begin
          next_item  = queued_fractions.pop_front();
          next_valid = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
          end else begin
            burst_left--;
          end
        end
        fraction_ch.valid <= next_valid;
        if (next_valid) begin
          fraction_ch.numerator   <= next_item.numerator;
          fraction_ch.denominator <= next_item.denominator;
        end
      end
    end
  end

  // Compare one result field against its expectation
  function automatic void check_field(string field, value_t expected_value,
                                      value_t actual_value);
    if (expected_value !== actual_value) begin
      $error("%s mismatch: expected %0d, got %0d", field, expected_value,
             actual_value);
      error_count++;
    end
  endfunction

  // Monitor: check results, stall on a changing duty pattern, hold off twice
  int stall_pct     = 0;
  int pattern_left  = 0;
  int hold_left     = 0;
  int next_hold_at  = 400;

  always @(posedge clk) begin
    reduced_t exp_result;
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (pending_reductions.size() == 0) begin
          $error("unexpected result transaction: %0d/%0d divisor %0d",
                 result_ch.reduced_numerator, result_ch.reduced_denominator,
                 result_ch.common_divisor);
          error_count++;
        end else begin
          exp_result = pending_reductions.pop_front();
          check_field("reduced_numerator", exp_result.numerator,
                      result_ch.reduced_numerator);
          check_field("reduced_denominator", exp_result.denominator,
                      result_ch.reduced_denominator);
          check_field("common_divisor", exp_result.divisor,
                      result_ch.common_divisor);
          check_field("zero_error", value_t'(exp_result.zero_error),
                      value_t'(result_ch.zero_error));
          if (exp_result.zero_error) zero_results++;
        end
        results_checked++;
      end
      // long hold-off so the block backs up and stalls its input
      if (hold_left == 0 && results_checked >= next_hold_at) begin
        hold_left    = HOLD_CYCLES;
        next_hold_at = (next_hold_at == 400) ? 900 : 32'h7fffffff;
        holds_done++;
      end
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(50, 400);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          2:       stall_pct = 70;
          default: stall_pct = 95;
        endcase
      end else begin
        pattern_left--;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: count cycles without any transaction
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((fraction_ch.valid && fraction_ch.ready) ||
        (result_ch.valid && result_ch.ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    fraction_ch.valid       = 1'b0;
    fraction_ch.numerator   = '0;
    fraction_ch.denominator = '0;
    result_ch.ready         = 1'b0;
    rst                     = 1'b1;

    // zero parts
    queued_fractions.push_back(make_fraction('0, '0));
    queued_fractions.push_back(make_fraction('0, value_t'(5)));
    queued_fractions.push_back(make_fraction(value_t'(7), '0));
    queued_fractions.push_back(make_fraction('0, VALUE_MAX));
    queued_fractions.push_back(make_fraction(VALUE_MAX, '0));
    // equal parts
    queued_fractions.push_back(make_fraction(value_t'(1), value_t'(1)));
    queued_fractions.push_back(make_fraction(VALUE_MAX, VALUE_MAX));
    queued_fractions.push_back(make_fraction(value_t'(12345), value_t'(12345)));
    // extremes and coprime neighbors
    queued_fractions.push_back(make_fraction(value_t'(1), VALUE_MAX));
    queued_fractions.push_back(make_fraction(VALUE_MAX, value_t'(1)));
    queued_fractions.push_back(make_fraction(VALUE_MAX, VALUE_MAX - value_t'(1)));
    // powers of two
    queued_fractions.push_back(make_fraction(value_t'(1) << 30, value_t'(1) << 29));
    queued_fractions.push_back(make_fraction(value_t'(32'h6000_0000),
                                             value_t'(32'h4000_0000)));
    queued_fractions.push_back(make_fraction(value_t'(1) << 30, value_t'(3)));
    // textbook cases
    queued_fractions.push_back(make_fraction(value_t'(48), value_t'(18)));
    queued_fractions.push_back(make_fraction(value_t'(17), value_t'(5)));
    queued_fractions.push_back(make_fraction(value_t'(1071), value_t'(462)));
    // consecutive Fibonacci numbers: longest Euclid chain
    queued_fractions.push_back(make_fraction(value_t'(1836311903),
                                             value_t'(1134903170)));
    // alternating bit patterns
    queued_fractions.push_back(make_fraction(value_t'(32'h5555_5555),
                                             value_t'(32'h2aaa_aaaa)));
    queued_fractions.push_back(make_fraction(value_t'(32'h2aaa_aaaa),
                                             value_t'(32'h5555_5555)));
    directed_count = queued_fractions.size();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      queued_fractions.push_back(random_fraction());
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // wait for all fractions to go in, then for all results to come out
    while (fractions_sent < directed_count + RANDOM_ITEMS) @(posedge clk);
    while (pending_reductions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d fractions (%0d directed, %0d random); checked %0d results",
             fractions_sent, directed_count, RANDOM_ITEMS, results_checked);
    $display("%0d results had a zero part; %0d long output hold-offs applied",
             zero_results, holds_done);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
